// ----- rtl/tga_rle_image_decoder_macros.svh -----
// Assertion macros used by the checker file of the TGA decoder.
`ifndef TGA_RLE_IMAGE_DECODER_MACROS_SVH
`define TGA_RLE_IMAGE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGA_DEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGA_DEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tga_dec_pkg.sv -----
package tga_dec_pkg;

  // Header layout.
  localparam logic [8:0] HDR_ID_LEN   = 9'd0;
  localparam logic [8:0] HDR_TYPE     = 9'd2;
  localparam logic [8:0] HDR_WIDTH_LO = 9'd12;
  localparam logic [8:0] HDR_WIDTH_HI = 9'd13;
  localparam logic [8:0] HDR_HEIGHT_LO = 9'd14;
  localparam logic [8:0] HDR_HEIGHT_HI = 9'd15;
  localparam logic [8:0] HDR_DEPTH    = 9'd16;
  localparam logic [8:0] HDR_LAST     = 9'd17;

  // Image type code for run-length coded true-color data.
  localparam logic [7:0] RLE_TYPE = 8'd10;

  // Depth byte shifted right by three equals this code for 4-byte pixels.
  localparam logic [4:0] DEPTH32_CODE = 5'd4;

  // Largest run a packet can describe.
  localparam logic [7:0] MAX_RUN = 8'd128;

  // One decoded run.
  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic [31:0] start_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        image_done;
  } run_t;

endpackage

// ----- rtl/tga_dec_ifs.sv -----
// Input channel: one file byte per item.
interface tga_dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

// Result channel: one decoded run per item.
interface tga_dec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  run_length;
  logic [31:0] start_index;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        image_done;

  modport source (output valid, output pixel_value, output run_length, output start_index,
                  output image_width, output image_height, output image_done,
                  input ready);
  modport sink (input valid, input pixel_value, input run_length, input start_index,
                input image_width, input image_height, input image_done,
                output ready);
endinterface

// ----- rtl/tga_dec_parser.sv -----
module tga_dec_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic                file_start,
  output logic                res_valid,
  output tga_dec_pkg::run_t   res
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_IDSKIP, PH_PACKET, PH_REPEAT, PH_RAW, PH_PLAIN, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt, c_phase;
  logic [8:0]  hc_r, hc_nxt, c_hc;
  logic [7:0]  id_len_r, id_len_nxt, c_id_len;
  logic        rle_r, rle_nxt, c_rle;
  logic        four_r, four_nxt, c_four;
  logic [15:0] width_r, width_nxt, c_width;
  logic [15:0] height_r, height_nxt, c_height;
  logic [31:0] total_r, total_nxt, c_total;
  logic [31:0] next_idx_r, next_idx_nxt, c_next;
  logic [7:0]  raw_rem_r, raw_rem_nxt, c_raw_rem;
  logic [7:0]  rep_len_r, rep_len_nxt, c_rep_len;
  logic [1:0]  bip_r, bip_nxt, c_bip;
  logic [31:0] asm_r, asm_nxt, c_asm;

  logic [31:0] byte_sh;
  logic [31:0] asm_acc;
  logic        pix_done;
  logic [31:0] left;
  logic        rep_clip;
  logic [7:0]  run_len;
  logic        run_done;
  logic        emit;
  logic        no_pixels;
  phase_t      pix_phase;

  // A file start clears the whole state before the byte is taken.
  always_comb begin
    if (file_start) begin
      c_phase   = PH_HEADER;
      c_hc      = '0;
      c_id_len  = '0;
      c_rle     = 1'b0;
      c_four    = 1'b0;
      c_width   = '0;
      c_height  = '0;
      c_total   = '0;
      c_next    = '0;
      c_raw_rem = '0;
      c_rep_len = '0;
      c_bip     = '0;
      c_asm     = '0;
    end else begin
      c_phase   = phase_r;
      c_hc      = hc_r;
      c_id_len  = id_len_r;
      c_rle     = rle_r;
      c_four    = four_r;
      c_width   = width_r;
      c_height  = height_r;
      c_total   = total_r;
      c_next    = next_idx_r;
      c_raw_rem = raw_rem_r;
      c_rep_len = rep_len_r;
      c_bip     = bip_r;
      c_asm     = asm_r;
    end
  end

  // Pixel assembly and run length terms.
  always_comb begin
    byte_sh  = {24'd0, data_byte} << {c_bip, 3'b000};
    asm_acc  = c_asm | byte_sh;
    pix_done = c_four ? (c_bip == 2'd3) : (c_bip >= 2'd2);
    left     = c_total - c_next;
    rep_clip = (left[31:8] == 24'd0) && (left[7:0] <= c_rep_len);
    if (c_phase == PH_REPEAT) begin
      run_len  = rep_clip ? left[7:0] : c_rep_len;
      run_done = rep_clip;
    end else begin
      run_len  = 8'd1;
      run_done = (left[31:1] == 31'd0);
    end
    no_pixels = (c_width == 16'd0) || (c_height == 16'd0);
    pix_phase = no_pixels ? PH_DONE : (c_rle ? PH_PACKET : PH_PLAIN);
  end

  // Next-state logic for one byte.
  always_comb begin
    phase_nxt    = c_phase;
    hc_nxt       = c_hc;
    id_len_nxt   = c_id_len;
    rle_nxt      = c_rle;
    four_nxt     = c_four;
    width_nxt    = c_width;
    height_nxt   = c_height;
    total_nxt    = c_total;
    next_idx_nxt = c_next;
    raw_rem_nxt  = c_raw_rem;
    rep_len_nxt  = c_rep_len;
    bip_nxt      = c_bip;
    asm_nxt      = c_asm;
    emit         = 1'b0;

    case (c_phase)
      PH_HEADER: begin
        case (c_hc)
          tga_dec_pkg::HDR_ID_LEN:    id_len_nxt = data_byte;
          tga_dec_pkg::HDR_TYPE:      rle_nxt = (data_byte == tga_dec_pkg::RLE_TYPE);
          tga_dec_pkg::HDR_WIDTH_LO:  width_nxt = {c_width[15:8], data_byte};
          tga_dec_pkg::HDR_WIDTH_HI:  width_nxt = {data_byte, c_width[7:0]};
          tga_dec_pkg::HDR_HEIGHT_LO: height_nxt = {c_height[15:8], data_byte};
          tga_dec_pkg::HDR_HEIGHT_HI: height_nxt = {data_byte, c_height[7:0]};
          tga_dec_pkg::HDR_DEPTH:     four_nxt = (data_byte[7:3] == tga_dec_pkg::DEPTH32_CODE);
          default: ;
        endcase
        if (c_hc >= tga_dec_pkg::HDR_LAST) begin
          hc_nxt    = '0;
          total_nxt = {16'd0, c_width} * {16'd0, c_height};
          if (c_id_len != 8'd0) begin
            phase_nxt = PH_IDSKIP;
          end else begin
            next_idx_nxt = '0;
            bip_nxt      = '0;
            asm_nxt      = '0;
            phase_nxt    = pix_phase;
          end
        end else begin
          hc_nxt = c_hc + 9'd1;
        end
      end
      PH_IDSKIP: begin
        hc_nxt = c_hc + 9'd1;
        if ((c_hc + 9'd1) >= {1'b0, c_id_len}) begin
          hc_nxt       = '0;
          next_idx_nxt = '0;
          bip_nxt      = '0;
          asm_nxt      = '0;
          phase_nxt    = pix_phase;
        end
      end
      PH_PACKET: begin
        if (data_byte[7]) begin
          rep_len_nxt = {1'b0, data_byte[6:0]} + 8'd1;
          phase_nxt   = PH_REPEAT;
        end else begin
          raw_rem_nxt = data_byte + 8'd1;
          phase_nxt   = PH_RAW;
        end
        bip_nxt = '0;
        asm_nxt = '0;
      end
      PH_REPEAT, PH_RAW, PH_PLAIN: begin
        if (!pix_done) begin
          asm_nxt = asm_acc;
          bip_nxt = c_bip + 2'd1;
        end else begin
          emit         = 1'b1;
          asm_nxt      = '0;
          bip_nxt      = '0;
          next_idx_nxt = c_next + {24'd0, run_len};
          if (run_done) begin
            phase_nxt = PH_DONE;
          end else if (c_phase == PH_REPEAT) begin
            phase_nxt = PH_PACKET;
          end else if (c_phase == PH_RAW) begin
            raw_rem_nxt = c_raw_rem - 8'd1;
            if (c_raw_rem == 8'd1) begin
              phase_nxt = PH_PACKET;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Result of this byte, if it completes a run.
  always_comb begin
    res_valid        = in_fire && emit;
    res.pixel_value  = asm_acc;
    res.run_length   = run_len;
    res.start_index  = c_next;
    res.image_width  = c_width;
    res.image_height = c_height;
    res.image_done   = run_done;
  end

  // Decoder state, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hc_r       <= '0;
      id_len_r   <= '0;
      rle_r      <= 1'b0;
      four_r     <= 1'b0;
      width_r    <= '0;
      height_r   <= '0;
      total_r    <= '0;
      next_idx_r <= '0;
      raw_rem_r  <= '0;
      rep_len_r  <= '0;
      bip_r      <= '0;
      asm_r      <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      hc_r       <= hc_nxt;
      id_len_r   <= id_len_nxt;
      rle_r      <= rle_nxt;
      four_r     <= four_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      total_r    <= total_nxt;
      next_idx_r <= next_idx_nxt;
      raw_rem_r  <= raw_rem_nxt;
      rep_len_r  <= rep_len_nxt;
      bip_r      <= bip_nxt;
      asm_r      <= asm_nxt;
    end
  end

endmodule

// ----- rtl/tga_dec_outbuf.sv -----
module tga_dec_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  tga_dec_pkg::run_t res,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tga_dec_pkg::run_t out_data
);

  logic              main_v_r;
  logic              skid_v_r;
  tga_dec_pkg::run_t main_r;
  tga_dec_pkg::run_t skid_r;

  // The skid entry catches a result produced while the output is stalled.
  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // Control bits of the two-entry result buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      main_v_r <= skid_v_r || res_valid;
      skid_v_r <= 1'b0;
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload of the two entries.
  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      main_r <= skid_v_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

endmodule

// ----- rtl/tga_rle_image_decoder.sv -----
// TGA decoder: takes a TGA file one byte per item and returns decoded pixel runs.
// Assert file_start with the first byte of every file. The 18-byte header is
// parsed, the ID field skipped, and the pixel data (run-length coded for image
// type 10, plain otherwise) comes out as runs of value, length and linear start
// index; depths 32-39 give 4-byte pixels, other depths 3-byte pixels with A = 0.
// A byte is taken in every cycle while ready is high, and at most one run comes
// out per byte, registered in the output buffer from the byte that completes its
// pixel; all per-byte work is a single pass of counter and register updates. A
// two-entry output buffer absorbs one extra run while the output is stalled; ready
// drops only when both entries hold runs. Bytes after the last pixel produce nothing.
module tga_rle_image_decoder (
  input  logic          clk,
  input  logic          rst_n,
  tga_dec_in_if.sink    in_if,
  tga_dec_out_if.source out_if
);

  logic              in_fire;
  logic              in_ready;
  logic              res_valid;
  tga_dec_pkg::run_t res;
  tga_dec_pkg::run_t out_data;

  assign in_if.ready = in_ready;
  assign in_fire     = in_if.valid && in_ready;

  // Header parser and run decoder.
  tga_dec_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_if.data_byte),
    .file_start (in_if.file_start),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register with skid entry.
  tga_dec_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  assign out_if.pixel_value  = out_data.pixel_value;
  assign out_if.run_length   = out_data.run_length;
  assign out_if.start_index  = out_data.start_index;
  assign out_if.image_width  = out_data.image_width;
  assign out_if.image_height = out_data.image_height;
  assign out_if.image_done   = out_data.image_done;

endmodule

// ----- rtl/tga_dec_checker.sv -----
`include "tga_rle_image_decoder_macros.svh"

module tga_dec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_value,
  input logic [7:0]  run_length,
  input logic [31:0] start_index,
  input logic [15:0] image_width,
  input logic [15:0] image_height,
  input logic        image_done
);

  logic [31:0] area;
  logic [32:0] run_end;

  // Pixel count of the image and the index just past the current run.
  assign area    = {16'd0, image_width} * {16'd0, image_height};
  assign run_end = {1'b0, start_index} + {25'd0, run_length};

  // A run always covers between one pixel and a full packet.
  `TGA_DEC_ASSERT_IMP(a_run_len, clk, rst_n, out_valid, run_length != 8'd0 && run_length <= tga_dec_pkg::MAX_RUN, "run length out of range")

  // An empty image never produces a run.
  `TGA_DEC_ASSERT_IMP(a_dims, clk, rst_n, out_valid, image_width != 16'd0 && image_height != 16'd0, "run produced for an empty image")

  // A run ends inside the image and the done flag marks exactly the final run.
  `TGA_DEC_ASSERT_IMP(a_bound, clk, rst_n, out_valid, image_done ? (run_end == {1'b0, area}) : (run_end < {1'b0, area}), "run end disagrees with image size or done flag")

  // A stalled run stays in place.
  `TGA_DEC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_value) && $stable(start_index) && $stable(run_length), "stalled run changed")

endmodule

bind tga_rle_image_decoder tga_dec_checker u_tga_dec_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .pixel_value  (out_if.pixel_value),
  .run_length   (out_if.run_length),
  .start_index  (out_if.start_index),
  .image_width  (out_if.image_width),
  .image_height (out_if.image_height),
  .image_done   (out_if.image_done)
);
